// ----- rtl/storage_tank_pump_mass_balance_macros.svh -----
// Assertion macros used by the checker file of the storage basin block
`ifndef STORAGE_TANK_PUMP_MASS_BALANCE_MACROS_SVH
`define STORAGE_TANK_PUMP_MASS_BALANCE_MACROS_SVH

// Same-cycle implication, disabled while reset is high
`define STPMB_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("storage basin check failed");

// Next-cycle implication, disabled while reset is high
`define STPMB_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("storage basin check failed");

// Condition that must hold in the cycle after reset
`define STPMB_ASSERT_RST(label, clk, rst, cons) \
   label: assert property (@(posedge clk) (rst) |=> (cons)) \
      else $error("storage basin reset check failed");

`endif

// ----- rtl/stpmb_pkg.sv -----
// Shared constants and types of the storage basin pump block
package stpmb_pkg;

   localparam int NUM_PUMPS      = 2;
   localparam int NUM_POLLUTANTS = 4;

   localparam int VOL_W     = 32;
   localparam int CONC_W    = 32;
   localparam int LOAD_W    = 63;
   localparam int STEP_W    = 17;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_W     = 32;
   localparam int PROD_W    = 64;
   localparam int PUMP_W    = 1;
   localparam int POLL_W    = 2;

   // divider: 95 bit dividend (pumped * load), 32 bit divisor
   localparam int DIV_W     = 95;
   localparam int DIV_CNT_W = 7;
   localparam logic [DIV_CNT_W-1:0] DIV_CNT_CONC = DIV_CNT_W'(LOAD_W);
   localparam logic [DIV_CNT_W-1:0] DIV_CNT_REM  = DIV_CNT_W'(DIV_W);

   localparam logic [LOAD_W-1:0] LOAD_MAX = '1;
   localparam logic [CONC_W-1:0] CONC_MAX = '1;
   localparam logic [VOL_W-1:0]  VOL_MAX  = '1;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_RATE_FIRST  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RATE_SECOND = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_FIRST   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_SECOND  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_STEP        = 3'd4;
   localparam logic [STEP_W-1:0]    STEP_RESET      = 17'd60;

   typedef enum logic [1:0] {
      MUL_LOAD,
      MUL_DRAW,
      MUL_PLO,
      MUL_PHI
   } mul_sel_type;

   typedef struct packed {
      logic              take;
      logic              mul_en;
      mul_sel_type       mul_sel;
      logic              load_add;
      logic              tgt_calc;
      logic              qdiv_start;
      logic              conc_wr;
      logic              acc_lo;
      logic              acc_hi;
      logic              rdiv_start;
      logic              load_sub;
      logic              out_load;
      logic [PUMP_W-1:0] pump;
      logic [POLL_W-1:0] poll;
   } cmd_type;

   typedef struct packed {
      logic div_done;
      logic active;
   } status_type;

endpackage

// ----- rtl/stpmb_div.sv -----
// Restoring divider, one quotient bit per cycle
module stpmb_div (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   input  logic [stpmb_pkg::DIV_W-1:0]          dividend,
   input  logic [stpmb_pkg::VOL_W-1:0]          divisor,
   input  logic [stpmb_pkg::DIV_CNT_W-1:0]      count,
   output logic [stpmb_pkg::DIV_W-1:0]          quotient,
   output logic                                 done
);

   logic [stpmb_pkg::DIV_W-1:0]     dvd_ff, dvd_in;
   logic [stpmb_pkg::DIV_W-1:0]     quo_ff, quo_in;
   logic [stpmb_pkg::VOL_W-1:0]     rem_ff, rem_in;
   logic [stpmb_pkg::VOL_W-1:0]     dsr_ff, dsr_in;
   logic [stpmb_pkg::DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                            busy_ff, busy_in;
   logic                            done_ff, done_in;
   logic [stpmb_pkg::VOL_W:0]       trial;
   logic                            fits;

   // one shift-subtract step
   always_comb begin
      trial   = {rem_ff, dvd_ff[stpmb_pkg::DIV_W-1]};
      fits    = trial >= {1'b0, dsr_ff};
      dvd_in  = dvd_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         dvd_in  = dividend;
         quo_in  = '0;
         rem_in  = '0;
         dsr_in  = divisor;
         cnt_in  = count;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = fits ? stpmb_pkg::VOL_W'(trial - {1'b0, dsr_ff})
                       : trial[stpmb_pkg::VOL_W-1:0];
         quo_in = {quo_ff[stpmb_pkg::DIV_W-2:0], fits};
         dvd_in = {dvd_ff[stpmb_pkg::DIV_W-2:0], 1'b0};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == stpmb_pkg::DIV_CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      dvd_ff <= dvd_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign quotient = quo_ff;
   assign done     = done_ff;

endmodule

// ----- rtl/stpmb_dp.sv -----
// Datapath: registers, basin state, shared multiplier and divider
module stpmb_dp (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_write_en,
   input  logic [stpmb_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [stpmb_pkg::CSR_W-1:0]        csr_data,
   input  logic [stpmb_pkg::VOL_W-1:0]        inflow_volume,
   input  logic [stpmb_pkg::CONC_W-1:0]       inflow_conc_a,
   input  logic [stpmb_pkg::CONC_W-1:0]       inflow_conc_b,
   input  logic [stpmb_pkg::CONC_W-1:0]       inflow_conc_c,
   input  logic [stpmb_pkg::CONC_W-1:0]       inflow_conc_d,
   input  stpmb_pkg::cmd_type                 cmd,
   output stpmb_pkg::status_type              status,
   output logic                               pump_index,
   output logic [stpmb_pkg::VOL_W-1:0]        pumped_volume,
   output logic [stpmb_pkg::CONC_W-1:0]       out_conc_a,
   output logic [stpmb_pkg::CONC_W-1:0]       out_conc_b,
   output logic [stpmb_pkg::CONC_W-1:0]       out_conc_c,
   output logic [stpmb_pkg::CONC_W-1:0]       out_conc_d,
   output logic [stpmb_pkg::VOL_W-1:0]        volume_after,
   output logic [stpmb_pkg::LOAD_W-1:0]       first_load_after,
   output logic                               last_of_step
);

   // configuration
   logic [stpmb_pkg::VOL_W-1:0]  rate_ff [stpmb_pkg::NUM_PUMPS];
   logic [stpmb_pkg::VOL_W-1:0]  min_ff  [stpmb_pkg::NUM_PUMPS];
   logic [stpmb_pkg::STEP_W-1:0] step_ff;

   // basin state
   logic [stpmb_pkg::VOL_W-1:0]  vol_ff;
   logic [stpmb_pkg::LOAD_W-1:0] load_ff [stpmb_pkg::NUM_POLLUTANTS];

   // request and working registers
   logic [stpmb_pkg::VOL_W-1:0]  inflow_ff;
   logic [stpmb_pkg::CONC_W-1:0] cin_ff  [stpmb_pkg::NUM_POLLUTANTS];
   logic [stpmb_pkg::CONC_W-1:0] conc_ff [stpmb_pkg::NUM_POLLUTANTS];
   logic [stpmb_pkg::PROD_W-1:0] prod_ff;
   logic [stpmb_pkg::DIV_W-1:0]  acc_ff;
   logic [stpmb_pkg::VOL_W-1:0]  target_ff;
   logic [stpmb_pkg::VOL_W-1:0]  pumped_ff;
   logic                         pumping_ff;

   // response registers
   logic                         rsp_pump_ff;
   logic [stpmb_pkg::VOL_W-1:0]  rsp_pumped_ff;
   logic [stpmb_pkg::CONC_W-1:0] rsp_conc_ff [4];
   logic [stpmb_pkg::VOL_W-1:0]  rsp_vol_ff;
   logic [stpmb_pkg::LOAD_W-1:0] rsp_load_ff;
   logic                         rsp_last_ff;

   logic [stpmb_pkg::CONC_W-1:0] cin_all [4];
   logic [stpmb_pkg::VOL_W-1:0]  mul_a;
   logic [stpmb_pkg::VOL_W-1:0]  mul_b;
   logic [stpmb_pkg::PROD_W-1:0] mul_p;
   logic [stpmb_pkg::LOAD_W-1:0] prod_sat;
   logic [stpmb_pkg::PROD_W-1:0] load_sum;
   logic [stpmb_pkg::LOAD_W-1:0] load_cur;
   logic [stpmb_pkg::VOL_W:0]    vol_sum;
   logic [stpmb_pkg::VOL_W-1:0]  tgt_base;
   logic [stpmb_pkg::VOL_W-1:0]  tgt;
   logic                         div_start;
   logic [stpmb_pkg::DIV_W-1:0]  div_dvd;
   logic [stpmb_pkg::DIV_CNT_W-1:0] div_cnt;
   logic [stpmb_pkg::DIV_W-1:0]  quo;
   logic                         div_done;
   logic [stpmb_pkg::CONC_W-1:0] quo_sat;

   assign cin_all[0] = inflow_conc_a;
   assign cin_all[1] = inflow_conc_b;
   assign cin_all[2] = inflow_conc_c;
   assign cin_all[3] = inflow_conc_d;

   assign load_cur = load_ff[cmd.poll];

   // shared 32x32 multiplier operand select
   always_comb begin
      case (cmd.mul_sel)
         stpmb_pkg::MUL_LOAD: begin
            mul_a = inflow_ff;
            mul_b = cin_ff[cmd.poll];
         end
         stpmb_pkg::MUL_DRAW: begin
            mul_a = rate_ff[cmd.pump];
            mul_b = stpmb_pkg::VOL_W'(step_ff);
         end
         stpmb_pkg::MUL_PLO: begin
            mul_a = pumped_ff;
            mul_b = load_cur[31:0];
         end
         stpmb_pkg::MUL_PHI: begin
            mul_a = pumped_ff;
            mul_b = {1'b0, load_cur[stpmb_pkg::LOAD_W-1:32]};
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end
   assign mul_p = stpmb_pkg::PROD_W'(mul_a) * stpmb_pkg::PROD_W'(mul_b);

   // saturating load accumulate
   assign prod_sat = (prod_ff > {1'b0, stpmb_pkg::LOAD_MAX}) ? stpmb_pkg::LOAD_MAX
                                                             : prod_ff[stpmb_pkg::LOAD_W-1:0];
   assign load_sum = {1'b0, load_cur} + {1'b0, prod_sat};

   assign vol_sum = {1'b0, vol_ff} + {1'b0, inflow_volume};

   // pump target: volume minus draw, floored at the pump minimum
   assign tgt_base = (prod_ff >= stpmb_pkg::PROD_W'(vol_ff)) ? '0
                                                             : vol_ff - prod_ff[31:0];
   assign tgt      = (tgt_base < min_ff[cmd.pump]) ? min_ff[cmd.pump] : tgt_base;

   // divider operands
   assign div_start = cmd.qdiv_start | cmd.rdiv_start;
   assign div_dvd   = cmd.qdiv_start ? {load_cur, 32'b0} : acc_ff;
   assign div_cnt   = cmd.qdiv_start ? stpmb_pkg::DIV_CNT_CONC : stpmb_pkg::DIV_CNT_REM;
   assign quo_sat   = (|quo[stpmb_pkg::DIV_W-1:stpmb_pkg::CONC_W]) ? stpmb_pkg::CONC_MAX
                                                                   : quo[31:0];

   stpmb_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dvd),
      .divisor  (vol_ff),
      .count    (div_cnt),
      .quotient (quo),
      .done     (div_done)
   );

   assign status.div_done = div_done;
   assign status.active   = pumping_ff & (vol_ff != '0);

   // configuration and basin state
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < stpmb_pkg::NUM_PUMPS; i++) begin
            rate_ff[i] <= '0;
            min_ff[i]  <= '0;
         end
         step_ff <= stpmb_pkg::STEP_RESET;
         vol_ff  <= '0;
         for (int j = 0; j < stpmb_pkg::NUM_POLLUTANTS; j++) begin
            load_ff[j] <= '0;
         end
      end else begin
         if (csr_write_en) begin
            case (csr_index)
               stpmb_pkg::CSR_RATE_FIRST:  rate_ff[0] <= csr_data;
               stpmb_pkg::CSR_RATE_SECOND: rate_ff[stpmb_pkg::NUM_PUMPS-1] <= csr_data;
               stpmb_pkg::CSR_MIN_FIRST:   min_ff[0] <= csr_data;
               stpmb_pkg::CSR_MIN_SECOND:  min_ff[stpmb_pkg::NUM_PUMPS-1] <= csr_data;
               stpmb_pkg::CSR_STEP:        step_ff <= csr_data[stpmb_pkg::STEP_W-1:0];
               default: ;
            endcase
         end
         if (cmd.take) begin
            vol_ff <= vol_sum[stpmb_pkg::VOL_W] ? stpmb_pkg::VOL_MAX
                                                : vol_sum[stpmb_pkg::VOL_W-1:0];
         end else if (cmd.out_load && pumping_ff) begin
            vol_ff <= target_ff;
         end
         if (cmd.load_add) begin
            load_ff[cmd.poll] <= load_sum[stpmb_pkg::LOAD_W] ? stpmb_pkg::LOAD_MAX
                                                             : load_sum[stpmb_pkg::LOAD_W-1:0];
         end else if (cmd.load_sub) begin
            load_ff[cmd.poll] <= load_cur - quo[stpmb_pkg::LOAD_W-1:0];
         end
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      if (cmd.take) begin
         inflow_ff <= inflow_volume;
         for (int j = 0; j < stpmb_pkg::NUM_POLLUTANTS; j++) begin
            cin_ff[j] <= cin_all[j];
         end
      end
      if (cmd.mul_en) begin
         prod_ff <= mul_p;
      end
      if (cmd.acc_lo) begin
         acc_ff <= stpmb_pkg::DIV_W'(prod_ff);
      end else if (cmd.acc_hi) begin
         acc_ff <= acc_ff + {prod_ff[stpmb_pkg::LOAD_W-1:0], 32'b0};
      end
      if (cmd.tgt_calc) begin
         target_ff  <= tgt;
         pumping_ff <= vol_ff >= tgt;
         pumped_ff  <= (vol_ff >= tgt) ? vol_ff - tgt : '0;
         for (int j = 0; j < stpmb_pkg::NUM_POLLUTANTS; j++) begin
            conc_ff[j] <= '0;
         end
      end else if (cmd.conc_wr) begin
         conc_ff[cmd.poll] <= quo_sat;
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_pump_ff   <= cmd.pump;
         rsp_pumped_ff <= pumped_ff;
         for (int k = 0; k < 4; k++) begin
            rsp_conc_ff[k] <= (k < stpmb_pkg::NUM_POLLUTANTS) ? conc_ff[k] : '0;
         end
         rsp_vol_ff    <= pumping_ff ? target_ff : vol_ff;
         rsp_load_ff   <= load_ff[0];
         rsp_last_ff   <= cmd.pump == stpmb_pkg::PUMP_W'(stpmb_pkg::NUM_PUMPS - 1);
      end
   end

   assign pump_index       = rsp_pump_ff;
   assign pumped_volume    = rsp_pumped_ff;
   assign out_conc_a       = rsp_conc_ff[0];
   assign out_conc_b       = rsp_conc_ff[1];
   assign out_conc_c       = rsp_conc_ff[2];
   assign out_conc_d       = rsp_conc_ff[3];
   assign volume_after     = rsp_vol_ff;
   assign first_load_after = rsp_load_ff;
   assign last_of_step     = rsp_last_ff;

endmodule

// ----- rtl/stpmb_ctrl.sv -----
// Controller: sequences inflow, pumps and pollutants over the datapath
module stpmb_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  stpmb_pkg::status_type status,
   output stpmb_pkg::cmd_type    cmd
);

   typedef enum logic [3:0] {
      S_IDLE, S_LMUL, S_LADD, S_DRAW, S_TGT, S_CHECK, S_QDIV, S_QWAIT,
      S_PLO, S_PHI, S_ACC, S_RDIV, S_RWAIT, S_OUT
   } state_type;

   state_type                          state_ff, state_in;
   logic [stpmb_pkg::PUMP_W-1:0]       pump_ff, pump_in;
   logic [stpmb_pkg::POLL_W-1:0]       poll_ff, poll_in;
   logic                               rsp_valid_ff, rsp_valid_in;
   logic                               poll_last;
   logic                               pump_last;
   logic                               out_free;

   assign poll_last = poll_ff == stpmb_pkg::POLL_W'(stpmb_pkg::NUM_POLLUTANTS - 1);
   assign pump_last = pump_ff == stpmb_pkg::PUMP_W'(stpmb_pkg::NUM_PUMPS - 1);
   assign out_free  = !rsp_valid_ff || rsp_ready;

   // next state and commands
   always_comb begin
      state_in     = state_ff;
      pump_in      = pump_ff;
      poll_in      = poll_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd          = '0;
      cmd.pump     = pump_ff;
      cmd.poll     = poll_ff;
      cmd.mul_sel  = stpmb_pkg::MUL_LOAD;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.take = 1'b1;
               poll_in  = '0;
               state_in = S_LMUL;
            end
         end
         S_LMUL: begin
            cmd.mul_en = 1'b1;
            state_in   = S_LADD;
         end
         S_LADD: begin
            cmd.load_add = 1'b1;
            if (poll_last) begin
               pump_in  = '0;
               state_in = S_DRAW;
            end else begin
               poll_in  = poll_ff + 1'b1;
               state_in = S_LMUL;
            end
         end
         S_DRAW: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = stpmb_pkg::MUL_DRAW;
            state_in    = S_TGT;
         end
         S_TGT: begin
            cmd.tgt_calc = 1'b1;
            poll_in      = '0;
            state_in     = S_CHECK;
         end
         S_CHECK: begin
            state_in = status.active ? S_QDIV : S_OUT;
         end
         S_QDIV: begin
            cmd.qdiv_start = 1'b1;
            state_in       = S_QWAIT;
         end
         S_QWAIT: begin
            if (status.div_done) begin
               cmd.conc_wr = 1'b1;
               state_in    = S_PLO;
            end
         end
         S_PLO: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = stpmb_pkg::MUL_PLO;
            state_in    = S_PHI;
         end
         S_PHI: begin
            cmd.acc_lo  = 1'b1;
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = stpmb_pkg::MUL_PHI;
            state_in    = S_ACC;
         end
         S_ACC: begin
            cmd.acc_hi = 1'b1;
            state_in   = S_RDIV;
         end
         S_RDIV: begin
            cmd.rdiv_start = 1'b1;
            state_in       = S_RWAIT;
         end
         S_RWAIT: begin
            if (status.div_done) begin
               cmd.load_sub = 1'b1;
               if (poll_last) begin
                  state_in = S_OUT;
               end else begin
                  poll_in  = poll_ff + 1'b1;
                  state_in = S_QDIV;
               end
            end
         end
         S_OUT: begin
            if (out_free) begin
               cmd.out_load = 1'b1;
               rsp_valid_in = 1'b1;
               if (pump_last) begin
                  state_in = S_IDLE;
               end else begin
                  pump_in  = pump_ff + 1'b1;
                  state_in = S_DRAW;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         pump_ff      <= '0;
         poll_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pump_ff      <= pump_in;
         poll_ff      <= poll_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = state_ff == S_IDLE;
   assign rsp_valid = rsp_valid_ff;

endmodule

// ----- rtl/storage_tank_pump_mass_balance.sv -----
// Top level of the storage basin pump mass balance block
//
// One request is one simulation step: an inflow volume (Q24.8) and four
// inflow concentrations (Q16.16). The step adds the inflow to the basin,
// grows each pollutant load, then serves each pump in order and sends one
// response per pump; the response of the last pump has last_of_step set.
// Pump rates, minimum volumes and step length are written through the csr_
// port, where writes take effect on the next cycle. The user must write
// them only while the block is idle; the block itself does not enforce it.
//
// The block takes one request at a time. The shared restoring divider gives
// one bit per cycle for each concentration and for each removed load. A pump
// whose target lies above the basin volume, or one facing an empty basin,
// skips the divisions. req_ready is high only while idle; it rises again as
// the last response is loaded into the output register, so that response
// may still wait. A stalled receiver holds the block in front of the output
// register. Reset clears basin volume, loads, pump rates and minimum
// volumes, and sets the step length to 60 s.
module storage_tank_pump_mass_balance (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_write_en,
   input  logic [stpmb_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [stpmb_pkg::CSR_W-1:0]        csr_data,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [stpmb_pkg::VOL_W-1:0]        req_inflow_volume,
   input  logic [stpmb_pkg::CONC_W-1:0]       req_inflow_conc_a,
   input  logic [stpmb_pkg::CONC_W-1:0]       req_inflow_conc_b,
   input  logic [stpmb_pkg::CONC_W-1:0]       req_inflow_conc_c,
   input  logic [stpmb_pkg::CONC_W-1:0]       req_inflow_conc_d,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic                               rsp_pump_index,
   output logic [stpmb_pkg::VOL_W-1:0]        rsp_pumped_volume,
   output logic [stpmb_pkg::CONC_W-1:0]       rsp_out_conc_a,
   output logic [stpmb_pkg::CONC_W-1:0]       rsp_out_conc_b,
   output logic [stpmb_pkg::CONC_W-1:0]       rsp_out_conc_c,
   output logic [stpmb_pkg::CONC_W-1:0]       rsp_out_conc_d,
   output logic [stpmb_pkg::VOL_W-1:0]        rsp_volume_after,
   output logic [stpmb_pkg::LOAD_W-1:0]       rsp_first_load_after,
   output logic                               rsp_last_of_step
);

   stpmb_pkg::cmd_type    cmd;
   stpmb_pkg::status_type status;

   stpmb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   stpmb_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .csr_write_en     (csr_write_en),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .inflow_volume    (req_inflow_volume),
      .inflow_conc_a    (req_inflow_conc_a),
      .inflow_conc_b    (req_inflow_conc_b),
      .inflow_conc_c    (req_inflow_conc_c),
      .inflow_conc_d    (req_inflow_conc_d),
      .cmd              (cmd),
      .status           (status),
      .pump_index       (rsp_pump_index),
      .pumped_volume    (rsp_pumped_volume),
      .out_conc_a       (rsp_out_conc_a),
      .out_conc_b       (rsp_out_conc_b),
      .out_conc_c       (rsp_out_conc_c),
      .out_conc_d       (rsp_out_conc_d),
      .volume_after     (rsp_volume_after),
      .first_load_after (rsp_first_load_after),
      .last_of_step     (rsp_last_of_step)
   );

endmodule

// ----- rtl/stpmb_check.sv -----
// Port-level checker for the storage basin block, bound to the top level
`include "storage_tank_pump_mass_balance_macros.svh"

module stpmb_check (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_ready,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic                        rsp_pump_index,
   input logic [stpmb_pkg::VOL_W-1:0] rsp_pumped_volume,
   input logic                        rsp_last_of_step
);

   // a stalled response holds its data
   `STPMB_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_pumped_volume))

   // reset leaves the block idle with no response pending
   `STPMB_ASSERT_RST(a_reset_idle, clock, reset, !rsp_valid && req_ready)

   // the last flag marks exactly the final pump
   `STPMB_ASSERT_IMP(a_last_flag, clock, reset, rsp_valid, rsp_last_of_step == (rsp_pump_index == (stpmb_pkg::NUM_PUMPS - 1)))

   // a request in progress blocks the next one
   `STPMB_ASSERT_NXT(a_busy_after_req, clock, reset, req_valid && req_ready, !req_ready)

endmodule

bind storage_tank_pump_mass_balance stpmb_check u_check (.*);
